>>> hw/rtl/irle_pkg.sv
// Package for the IR range linearizer: field widths, fixed-point constants,
// curve coefficients and the elaboration-time builder for the power-law table.
// Depends on nothing.
package irle_pkg;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 10;
  localparam int FILT_W   = 18;
  localparam int DIST_W   = 18;
  localparam int WEIGHT_W = 16;
  localparam int ROM_W    = 17;
  localparam int X_W      = 19;
  localparam int H_W      = 36;

  localparam logic [WEIGHT_W-1:0] EMA_RESET = 16'd6554;
  localparam int DIST_MAX = 131071;
  localparam int DIST_MIN = -131072;

  // Volts in Q16 are (f*1568 + 625) / 1250; the divide is a reciprocal multiply.
  localparam logic [10:0] VOLT_MUL = 11'd1568;
  localparam logic [9:0]  VOLT_RND = 10'd625;
  localparam logic [29:0] RECIP_M  = 30'd879609303;
  localparam int          RECIP_SH = 40;

  // Curve kinds.
  localparam logic [1:0] CURVE_NONE = 2'd0;
  localparam logic [1:0] CURVE_POLY = 2'd1;
  localparam logic [1:0] CURVE_POW  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] row;
  } curve_t;

  // Quintic coefficients in thousandths, highest power first.
  localparam int POLY_MILLI [4][6] = '{
    '{-13696, 101400, -296490, 438400, -348660, 144170},
    '{-11577,  92006, -288750, 455000, -377910, 155370},
    '{-20988, 143170, -383550, 520200, -382960, 148660},
    '{-17686, 143290, -454790, 718360, -600200, 265990}
  };

  // Power law a * x^b, both in thousandths.
  localparam int POW_MILLI [2][2] = '{
    '{25863, -1268},
    '{26353, -1056}
  };

  // Map a channel to its curve.
  function automatic curve_t curve_of(input logic [CH_W-1:0] ch);
    curve_t c;
    c.kind = CURVE_NONE;
    c.row  = 2'd0;
    unique case (ch)
      3'd0: begin c.kind = CURVE_POLY; c.row = 2'd0; end
      3'd1: begin c.kind = CURVE_POLY; c.row = 2'd1; end
      3'd2: begin c.kind = CURVE_POW;  c.row = 2'd0; end
      3'd3: begin c.kind = CURVE_POLY; c.row = 2'd2; end
      3'd4: begin c.kind = CURVE_POW;  c.row = 2'd1; end
      3'd5: begin c.kind = CURVE_POLY; c.row = 2'd3; end
      default: begin c.kind = CURVE_NONE; c.row = 2'd0; end
    endcase
    return c;
  endfunction

  // Coefficient to Q16, rounded half away from zero.
  function automatic longint coef_q16(input int milli);
    longint m;
    longint q;
    m = (milli < 0) ? -longint'(milli) : longint'(milli);
    q = (m * 65536 + 500) / 1000;
    return (milli < 0) ? -q : q;
  endfunction

  // Horner coefficient k of polynomial row, as a constant table.
  function automatic logic signed [H_W-1:0] poly_coef(input logic [1:0] row,
                                                       input logic [2:0] k);
    if (k > 3'd5) return '0;
    return H_W'(coef_q16(POLY_MILLI[row][k]));
  endfunction

  // Base-2 logarithm in Q24 by repeated squaring, truncating.
  function automatic longint log2_fix(input longint unsigned v);
    int p;
    int b;
    int k;
    longint unsigned y;
    longint frac;
    p = 0;
    frac = 0;
    if (v == 0) return 0;
    for (b = 0; b < 64; b++) begin
      if (v[b]) p = b;
    end
    y = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (k = 23; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        frac = frac | (longint'(1) << k);
      end
    end
    return (longint'(p) << 24) + frac;
  endfunction

  // Distance for rounded count i on power row: largest d with log2(2d-1)-1 <= T.
  function automatic logic [ROM_W-1:0] pow_entry(input int row, input int i);
    longint a;
    longint bexp;
    longint lx;
    longint target;
    int lo;
    int hi;
    int mid;
    if (i == 0) return ROM_W'(DIST_MAX);
    a = POW_MILLI[row][0];
    bexp = POW_MILLI[row][1];
    lx = log2_fix(longint'(i) * 49) - log2_fix(10000);
    target = log2_fix(a * 16) - log2_fix(1000) + (bexp * lx) / 1000;
    lo = 0;
    hi = DIST_MAX;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (log2_fix(longint'(2 * mid - 1)) - (longint'(1) << 24) <= target) lo = mid;
      else hi = mid - 1;
    end
    return ROM_W'(lo);
  endfunction

endpackage

>>> hw/rtl/irle_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module irle_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ir_range_ema_linearizer.sv
// IR range linearizer, top level; uses irle_pkg and irle_ram. Each item carries a
// channel and a 10-bit sample; the block smooths it with a per-channel exponential
// average held in a small RAM (valid flags in flip-flops, so no clearing pass) and
// returns the filtered value with a distance in sixteenths of a centimeter. One item
// is worked on at a time. A polynomial channel steps from accept to result register
// through read, average multiply, filter write-back, two volt steps, five Horner
// steps of a low and a high partial product each, then rounding and saturation.
// A power-law channel reads a registered constant table of CURVE_TABLE_DEPTH
// entries per curve. A channel at or above CHANNELS goes straight to the result.
// The next item is accepted as soon as the result sits in the output register.
module ir_range_ema_linearizer #(
  parameter int CHANNELS = 6,
  parameter int CURVE_TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [irle_pkg::CH_W-1:0]             in_channel,
  input  logic [irle_pkg::SAMPLE_W-1:0]         in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [irle_pkg::CH_W-1:0]             out_channel_out,
  output logic [irle_pkg::FILT_W-1:0]           out_smoothed,
  output logic signed [irle_pkg::DIST_W-1:0]    out_distance,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  import irle_pkg::*;

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W = $clog2(CURVE_TABLE_DEPTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EMA  = 4'd1;
  localparam logic [3:0] ST_FILT = 4'd2;
  localparam logic [3:0] ST_VN   = 4'd3;
  localparam logic [3:0] ST_VQ   = 4'd4;
  localparam logic [3:0] ST_HLO  = 4'd5;
  localparam logic [3:0] ST_HHI  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_ROM  = 4'd8;
  localparam logic [3:0] ST_ROMD = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0]                state_r, state_nxt;
  logic [WEIGHT_W-1:0]       weight_r;
  logic [CHANNELS-1:0]       seeded_r;
  logic [CH_W-1:0]           ch_r;
  logic [AW-1:0]             addr_r;
  curve_t                    curve_r;
  logic [FILT_W-1:0]         s8_r;
  logic [FILT_W-1:0]         old_r;
  logic                      seed_r;
  logic signed [35:0]        prod_r;
  logic [FILT_W-1:0]         f_r;
  logic [28:0]               n_r;
  logic [X_W-1:0]            x_r;
  logic signed [H_W-1:0]     h_r;
  logic signed [46:0]        plo_r;
  logic [2:0]                k_r;
  logic [ROM_W-1:0]          rom_q_r;
  logic signed [DIST_W-1:0]  dist_r;
  logic                      out_valid_r;
  logic [CH_W-1:0]           out_ch_r;
  logic [FILT_W-1:0]         out_f_r;
  logic signed [DIST_W-1:0]  out_d_r;

  logic                      in_acc;
  logic                      ch_ok;
  logic                      cfg_we;
  logic                      ram_we;
  logic [FILT_W-1:0]         ram_rdata;
  logic [FILT_W-1:0]         old_val;
  logic signed [18:0]        diff;
  logic signed [36:0]        acc;
  logic [FILT_W-1:0]         f_nxt;
  logic [58:0]               vprod;
  logic signed [45:0]        phi;
  logic signed [57:0]        psum;
  logic signed [H_W:0]       hr;
  logic signed [24:0]        dq;
  logic [18:0]               rsum;
  logic [IDX_W-1:0]          ridx;
  logic [ROM_W-1:0]          pow_tab [2][CURVE_TABLE_DEPTH];

  // Power-law curves, built at elaboration.
  for (genvar gi = 0; gi < CURVE_TABLE_DEPTH; gi++) begin : g_pow
    localparam logic [ROM_W-1:0] E0 = pow_entry(0, gi);
    localparam logic [ROM_W-1:0] E1 = pow_entry(1, gi);
    assign pow_tab[0][gi] = E0;
    assign pow_tab[1][gi] = E1;
  end

  // Handshakes and register port.
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ch_ok     = (int'(in_channel) < CHANNELS);
  assign cfg_we    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'd0 : {16'd0, weight_r};
  assign out_valid = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_smoothed    = out_f_r;
  assign out_distance    = out_d_r;

  // Filter state store; read issued at accept, data used in the next cycle.
  irle_ram #(.WIDTH(FILT_W), .DEPTH(CHANNELS)) u_filt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (f_nxt),
    .raddr (AW'(in_channel)),
    .rdata (ram_rdata)
  );

  // Exponential average: f = old + w*(s - old), rounded; an unseeded channel takes s.
  assign old_val = seeded_r[addr_r] ? ram_rdata : '0;
  assign diff    = $signed({1'b0, s8_r}) - $signed({1'b0, old_val});
  assign acc     = $signed({3'b000, old_r, 16'd0}) + $signed({prod_r[35], prod_r})
                   + 37'sd32768;
  assign f_nxt   = seed_r ? acc[33:16] : s8_r;
  assign ram_we  = (state_r == ST_FILT);

  // Volts in Q16 from the reciprocal product.
  assign vprod = n_r * RECIP_M;

  // Upper half of the Horner product, combined with the lower half.
  assign phi  = h_r * $signed({1'b0, x_r[18:10]});
  assign psum = $signed({{11{plo_r[46]}}, plo_r}) + $signed({{2{phi[45]}}, phi, 10'd0})
                + 58'sd32768;

  // Final rounding to sixteenths of a centimeter.
  assign hr = $signed({h_r[H_W-1], h_r}) + 37'sd2048;
  assign dq = hr[H_W:12];

  // Rounded filtered count, clamped to the table.
  assign rsum = {1'b0, f_r} + 19'd128;
  assign ridx = (int'(rsum[18:8]) > CURVE_TABLE_DEPTH - 1) ?
                IDX_W'(CURVE_TABLE_DEPTH - 1) : IDX_W'(rsum[18:8]);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ch_ok ? ST_EMA : ST_DONE;
      ST_EMA:  state_nxt = ST_FILT;
      ST_FILT: begin
        if (curve_r.kind == CURVE_POLY) state_nxt = ST_VN;
        else if (curve_r.kind == CURVE_POW) state_nxt = ST_ROM;
        else state_nxt = ST_DONE;
      end
      ST_VN:   state_nxt = ST_VQ;
      ST_VQ:   state_nxt = ST_HLO;
      ST_HLO:  state_nxt = ST_HHI;
      ST_HHI:  state_nxt = (k_r == 3'd5) ? ST_FIN : ST_HLO;
      ST_FIN:  state_nxt = ST_DONE;
      ST_ROM:  state_nxt = ST_ROMD;
      ST_ROMD: state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      weight_r    <= EMA_RESET;
      seeded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && !paddr[2]) begin
        weight_r <= pwdata[15:0];
      end
      if (ram_we) begin
        seeded_r[addr_r] <= 1'b1;
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r    <= in_channel;
      addr_r  <= AW'(in_channel);
      curve_r <= curve_of(in_channel);
      s8_r    <= {in_sample, 8'd0};
      f_r     <= '0;
      dist_r  <= '0;
    end
    unique case (state_r)
      ST_EMA: begin
        old_r  <= old_val;
        seed_r <= seeded_r[addr_r];
        prod_r <= diff * $signed({1'b0, weight_r});
      end
      ST_FILT: begin
        f_r    <= f_nxt;
        dist_r <= '0;
      end
      ST_VN: n_r <= 29'(32'(f_r) * 32'(VOLT_MUL) + 32'(VOLT_RND));
      ST_VQ: begin
        x_r <= vprod[RECIP_SH +: X_W];
        h_r <= poly_coef(curve_r.row, 3'd0);
        k_r <= 3'd1;
      end
      ST_HLO: plo_r <= h_r * $signed({1'b0, x_r[9:0]});
      ST_HHI: begin
        h_r <= psum[51:16] + poly_coef(curve_r.row, k_r);
        k_r <= k_r + 3'd1;
      end
      ST_FIN: begin
        if (dq > 25'sd131071) dist_r <= DIST_W'(DIST_MAX);
        else if (dq < -25'sd131072) dist_r <= DIST_W'(DIST_MIN);
        else dist_r <= dq[DIST_W-1:0];
      end
      ST_ROM:  rom_q_r <= pow_tab[curve_r.row[0]][ridx];
      ST_ROMD: dist_r  <= $signed({1'b0, rom_q_r});
      default: ;
    endcase
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_ch_r <= ch_r;
      out_f_r  <= f_r;
      out_d_r  <= dist_r;
    end
  end

  // One item in flight: no accept right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("item accepted while another is in flight");

  // A channel without state gives zero results.
  a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && int'(out_channel_out) >= CHANNELS) |->
    (out_smoothed == '0 && out_distance == '0))
    else $error("nonzero result for unknown channel");

  // Every write-back marks its channel as seeded.
  a_seed_set: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> seeded_r[$past(addr_r)])
    else $error("filter written without seeded flag");

endmodule

>>> test/ir_range_ema_linearizer_tb.sv
// Self-checking testbench for the IR range linearizer: drives channel and sample
// items, writes the smoothing weight over the register port, and predicts each result.
// Depends on irle_pkg and the ir_range_ema_linearizer top level.
module ir_range_ema_linearizer_tb;
  import irle_pkg::*;

  localparam int NUM_CH = 6;
  localparam int TBL_DEPTH = 1024;
  localparam logic [2:0] REG_EMA_WEIGHT = 3'd0;

  // One result of the block.
  typedef struct {
    logic [CH_W-1:0] channel;
    logic [FILT_W-1:0] smoothed;
    logic signed [DIST_W-1:0] distance;
  } range_result_t;

  // Polynomial coefficients, thousandths, highest power first.
  localparam int QUINTIC_MILLI [4][6] = '{
    '{-13696, 101400, -296490, 438400, -348660, 144170},
    '{-11577, 92006, -288750, 455000, -377910, 155370},
    '{-20988, 143170, -383550, 520200, -382960, 148660},
    '{-17686, 143290, -454790, 718360, -600200, 265990}
  };
  localparam int POWER_MILLI [2][2] = '{'{25863, -1268}, '{26353, -1056}};

  // Predicts distances and holds the expected results in order.
  class range_scoreboard;
    logic [FILT_W-1:0] filt [NUM_CH];
    bit seen [NUM_CH];
    logic [WEIGHT_W-1:0] weight;
    int power_tbl [2][TBL_DEPTH];
    range_result_t pending [$];
    int errors;

    function longint log2_q24(longint unsigned v);
      int p;
      int k;
      longint unsigned y;
      longint fr;
      p = 0;
      fr = 0;
      if (v == 0) return 0;
      for (int b = 0; b < 64; b++) if (v[b]) p = b;
      y = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      for (k = 23; k >= 0; k--) begin
        y = (y * y) >> 30;
        if (y >= 64'h8000_0000) begin
          y = y >> 1;
          fr = fr | (longint'(1) << k);
        end
      end
      return (longint'(p) << 24) + fr;
    endfunction

    function int power_distance(int r, int i);
      longint lx;
      longint tgt;
      int lo;
      int hi;
      int mid;
      if (i == 0) return DIST_MAX;
      lx = log2_q24(longint'(i) * 49) - log2_q24(10000);
      tgt = log2_q24(longint'(POWER_MILLI[r][0]) * 16) - log2_q24(1000)
            + (longint'(POWER_MILLI[r][1]) * lx) / 1000;
      lo = 0;
      hi = DIST_MAX;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (log2_q24(longint'(2 * mid - 1)) - (longint'(1) << 24) <= tgt) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function new();
      errors = 0;
      weight = EMA_RESET;
      foreach (filt[c]) begin
        filt[c] = '0;
        seen[c] = 0;
      end
      for (int r = 0; r < 2; r++)
        for (int i = 0; i < TBL_DEPTH; i++) power_tbl[r][i] = power_distance(r, i);
    endfunction

    // Floor division by 2^s, correct for negative values.
    function longint floor_sh(longint p, int s);
      return p >>> s;
    endfunction

    function longint to_q16(int milli);
      longint m;
      longint q;
      m = (milli < 0) ? -longint'(milli) : longint'(milli);
      q = (m * 65536 + 500) / 1000;
      return (milli < 0) ? -q : q;
    endfunction

    function longint horner_distance(int r, logic [FILT_W-1:0] f);
      longint x;
      longint h;
      longint d;
      x = (longint'(f) * 1568 + 625) / 1250;
      h = to_q16(QUINTIC_MILLI[r][0]);
      for (int k = 1; k < 6; k++) h = floor_sh(h * x + 32768, 16) + to_q16(QUINTIC_MILLI[r][k]);
      d = floor_sh(h + 2048, 12);
      if (d > DIST_MAX) d = DIST_MAX;
      if (d < DIST_MIN) d = DIST_MIN;
      return d;
    endfunction

    // Note an accepted item and queue its expected result.
    function void note_item(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      range_result_t e;
      longint unsigned acc;
      logic [FILT_W-1:0] f;
      int idx;
      longint d;
      e.channel = ch;
      e.smoothed = '0;
      e.distance = '0;
      if (ch < NUM_CH) begin
        if (!seen[ch]) begin
          f = FILT_W'({smp, 8'd0});
          seen[ch] = 1;
        end else begin
          acc = longint'(weight) * (longint'(smp) << 8)
                + longint'(65536 - weight) * filt[ch] + 32768;
          f = FILT_W'(acc >> 16);
        end
        filt[ch] = f;
        idx = (int'(f) + 128) >> 8;
        if (idx > TBL_DEPTH - 1) idx = TBL_DEPTH - 1;
        case (ch)
          3'd0: d = horner_distance(0, f);
          3'd1: d = horner_distance(1, f);
          3'd2: d = power_tbl[0][idx];
          3'd3: d = horner_distance(2, f);
          3'd4: d = power_tbl[1][idx];
          default: d = horner_distance(3, f);
        endcase
        e.smoothed = f;
        e.distance = DIST_W'(d);
      end
      pending.push_back(e);
    endfunction

    // Compare an accepted result with the oldest expectation.
    function void check_result(range_result_t got);
      range_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: channel %0d", got.channel);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.channel !== e.channel) begin
        $error("channel_out: expected %0d, got %0d", e.channel, got.channel);
        errors++;
      end
      if (got.smoothed !== e.smoothed) begin
        $error("smoothed: expected %0d, got %0d", e.smoothed, got.smoothed);
        errors++;
      end
      if (got.distance !== e.distance) begin
        $error("distance: expected %0d, got %0d", e.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CH_W-1:0] in_channel;
  logic [SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_ready;
  logic [CH_W-1:0] out_channel_out;
  logic [FILT_W-1:0] out_smoothed;
  logic signed [DIST_W-1:0] out_distance;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  range_scoreboard sb;
  bit sending_done;

  ir_range_ema_linearizer #(.CHANNELS(NUM_CH), .CURVE_TABLE_DEPTH(TBL_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_channel(in_channel),
    .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel_out(out_channel_out),
    .out_smoothed(out_smoothed), .out_distance(out_distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Send one item, after a random gap, and hold it until accepted.
  task automatic send_item(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    sb.note_item(ch, smp);
    @(negedge clk);
  endtask

  // Stop sending, wait until every expected result is in, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_weight(logic [WEIGHT_W-1:0] w);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_EMA_WEIGHT;
    pwdata <= 32'(w);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.weight = w;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A sample that favors the extremes and covers all bits.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(0, 40));
      default: return SAMPLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Result side: a random wait before each item, check on every accepted result.
  initial begin
    range_result_t got;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.channel = out_channel_out;
      got.smoothed = out_smoothed;
      got.distance = out_distance;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // Stimulus.
  initial begin
    logic [WEIGHT_W-1:0] weights [6];
    sb = new();
    sending_done = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_channel = '0;
    in_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: seeding with extremes, channels past the last one, zero volts.
    for (int c = 0; c < NUM_CH; c++) send_item(CH_W'(c), (c % 2) ? '1 : '0);
    send_item(3'd6, '1);
    send_item(3'd7, 10'h2AA);
    for (int c = 0; c < NUM_CH; c++) send_item(CH_W'(c), (c % 2) ? '0 : '1);
    send_item(3'd2, 10'd0);
    send_item(3'd4, 10'd1);
    send_item(3'd0, 10'h155);
    send_item(3'd5, 10'h2AA);
    wait_drained();

    // Random phases, each under a different weight, extremes included.
    weights = '{16'd0, 16'hFFFF, 16'd32768, 16'd1, EMA_RESET, 16'd0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) weights[5] = WEIGHT_W'($urandom_range(0, 65535));
      write_weight(weights[ph]);
      for (int n = 0; n < 150; n++) begin
        logic [CH_W-1:0] ch;
        ch = ($urandom_range(0, 15) == 0) ? CH_W'($urandom_range(6, 7))
                                          : CH_W'($urandom_range(0, 5));
        send_item(ch, pick_sample());
      end
      wait_drained();
    end
    sending_done = 1;
  end

  // Final verdict once stimulus is done and everything has drained.
  initial begin
    wait (sending_done);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/irle_pkg.sv
hw/rtl/irle_ram.sv
hw/rtl/ir_range_ema_linearizer.sv
test/ir_range_ema_linearizer_tb.sv
